/* hdl/mlr_pkg.sv */
// Shared definitions for the midpoint line rasterizer.
// Holds the default coordinate width and the operation codes; no dependencies.
package mlr_pkg;

    localparam int COORD_BITS_DEF = 10;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

endpackage

/* hdl/mlr_in_reg.sv */
// Input register stage of the line rasterizer: captures one beat and hands it on.
// Depends on mlr_pkg for the operation type.
module mlr_in_reg #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mlr_pkg::op_t          op,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  s_valid,
    input  logic                  s_ready,
    output mlr_pkg::op_t          s_op,
    output logic [COORD_BITS-1:0] s_start_x,
    output logic [COORD_BITS-1:0] s_start_y,
    output logic [COORD_BITS-1:0] s_end_x,
    output logic [COORD_BITS-1:0] s_end_y
);
    import mlr_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    op_t                   op_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] ex_reg;
    logic [COORD_BITS-1:0] ey_reg;
    logic                  load_en;

    assign in_ready = !valid_reg || s_ready;
    assign load_en  = in_valid && in_ready;

    always_comb
    begin
        if (load_en)
        begin
            valid_next = 1'b1;
        end
        else if (s_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            op_reg <= op;
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
    end

    assign s_valid   = valid_reg;
    assign s_op      = op_reg;
    assign s_start_x = sx_reg;
    assign s_start_y = sy_reg;
    assign s_end_x   = ex_reg;
    assign s_end_y   = ey_reg;

endmodule

/* hdl/mlr_engine.sv */
// Line state, load setup, per-pixel midpoint step and output register.
// Depends on mlr_pkg for the operation codes.
module mlr_engine #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mlr_pkg::op_t          s_op,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic [COORD_BITS-1:0] dmaj_reg, dmaj_next;
    logic [COORD_BITS-1:0] dmin_reg, dmin_next;
    logic signed [DW-1:0]  decision_reg, decision_next;
    logic                  y_major_reg, y_major_next;
    logic                  minor_neg_reg, minor_neg_next;
    logic                  active_reg, active_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic                  last_reg;

    logic                  take;
    logic                  emit;

    logic [COORD_BITS-1:0] adx, ady;
    logic                  ld_y_major;
    logic                  ld_swap;
    logic [COORD_BITS-1:0] ld_sx, ld_sy, ld_ex, ld_ey;
    logic [COORD_BITS-1:0] ld_smin, ld_emin;
    logic [COORD_BITS-1:0] ld_dmaj, ld_dmin;

    logic [COORD_BITS-1:0] cur_major, cur_minor;
    logic [COORD_BITS-1:0] nxt_major, nxt_minor;
    logic                  is_last;
    logic signed [DW-1:0]  two_min, two_maj;

    assign s_ready = !out_valid_reg || out_ready;
    assign take    = s_valid && s_ready;
    assign emit    = take && (s_op == OP_TICK) && active_reg;

    always_comb
    begin
        adx = (s_start_x >= s_end_x) ? s_start_x - s_end_x : s_end_x - s_start_x;
        ady = (s_start_y >= s_end_y) ? s_start_y - s_end_y : s_end_y - s_start_y;
        ld_y_major = (ady >= adx) && (ady != '0);
        ld_swap    = ld_y_major ? (s_start_y > s_end_y) : (s_start_x > s_end_x);
        ld_sx   = ld_swap ? s_end_x   : s_start_x;
        ld_sy   = ld_swap ? s_end_y   : s_start_y;
        ld_ex   = ld_swap ? s_start_x : s_end_x;
        ld_ey   = ld_swap ? s_start_y : s_end_y;
        ld_smin = ld_y_major ? ld_sx : ld_sy;
        ld_emin = ld_y_major ? ld_ex : ld_ey;
        ld_dmaj = ld_y_major ? ady : adx;
        ld_dmin = ld_y_major ? adx : ady;
    end

    always_comb
    begin
        cur_major = y_major_reg ? cur_y_reg : cur_x_reg;
        cur_minor = y_major_reg ? cur_x_reg : cur_y_reg;
        is_last   = (cur_major == major_end_reg);
        two_min   = signed'({1'b0, dmin_reg, 1'b0});
        two_maj   = signed'({1'b0, dmaj_reg, 1'b0});
        nxt_major = cur_major + 1'b1;
        if (decision_reg >= 0)
        begin
            nxt_minor = minor_neg_reg ? cur_minor - 1'b1 : cur_minor + 1'b1;
        end
        else
        begin
            nxt_minor = cur_minor;
        end
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        decision_next  = decision_reg;
        y_major_next   = y_major_reg;
        minor_neg_next = minor_neg_reg;
        active_next    = active_reg;
        if (take && (s_op == OP_LOAD))
        begin
            cur_x_next     = ld_sx;
            cur_y_next     = ld_sy;
            major_end_next = ld_y_major ? ld_ey : ld_ex;
            dmaj_next      = ld_dmaj;
            dmin_next      = ld_dmin;
            decision_next  = signed'({1'b0, ld_dmin, 1'b0}) - signed'({2'b00, ld_dmaj});
            y_major_next   = ld_y_major;
            minor_neg_next = ld_emin < ld_smin;
            active_next    = 1'b1;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cur_x_next = y_major_reg ? nxt_minor : nxt_major;
                cur_y_next = y_major_reg ? nxt_major : nxt_minor;
                if (decision_reg >= 0)
                begin
                    decision_next = decision_reg + two_min - two_maj;
                end
                else
                begin
                    decision_next = decision_reg + two_min;
                end
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            dmaj_reg      <= '0;
            dmin_reg      <= '0;
            decision_reg  <= '0;
            y_major_reg   <= 1'b0;
            minor_neg_reg <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            dmaj_reg      <= dmaj_next;
            dmin_reg      <= dmin_next;
            decision_reg  <= decision_next;
            y_major_reg   <= y_major_next;
            minor_neg_reg <= minor_neg_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            last_reg    <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

endmodule

/* hdl/midpoint_line_rasterizer_unit.sv */
// Midpoint line rasterizer: top level joining the input register and the engine.
// Depends on mlr_pkg, mlr_in_reg and mlr_engine.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op plus two endpoints. A beat
//   with op = load sets up a new line and yields no output beat; a beat with
//   op = tick yields one pixel while a line is active, else nothing.
//   Output channel (out_valid/out_ready) carries pixel_x, pixel_y and last;
//   last marks the final endpoint, after which ticks give nothing until the
//   next load.
//   A tick is registered in the input register and its pixel then in the
//   output register. Throughput: one beat per cycle while out_ready is
//   high, set by the combinational step of the engine between them.
//   Stall: while out_ready is low the output beat holds; one more input
//   beat is held in the input register, then in_ready drops.
//   Reset: clears both registers' valid flags and the line state; no line
//   is active, so ticks give nothing until a load.
module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mlr_pkg::op_t          op,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last
);
    import mlr_pkg::*;

    logic                  s_valid;
    logic                  s_ready;
    op_t                   s_op;
    logic [COORD_BITS-1:0] s_start_x;
    logic [COORD_BITS-1:0] s_start_y;
    logic [COORD_BITS-1:0] s_end_x;
    logic [COORD_BITS-1:0] s_end_y;

    mlr_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y)
    );

    mlr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_start_x (s_start_x),
        .s_start_y (s_start_y),
        .s_end_x   (s_end_x),
        .s_end_y   (s_end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

endmodule
